// ----- hdl/twh_pkg.sv -----
// shared types, constants and helpers for the triangular lattice walk histogram
`default_nettype none
package twh_pkg;

  localparam int GRID = 32;
  localparam int BINS = GRID * GRID;
  localparam int ADDR_W = $clog2(BINS);
  localparam int COORD_W = 12;
  localparam int COUNT_W = 32;
  localparam int SPW_W = 10;
  localparam int BIN_W = 10;
  localparam int DIR_W = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [SPW_W-1:0] SPW_RESET = SPW_W'(100);
  localparam logic signed [COORD_W-1:0] CENTER = COORD_W'(GRID / 2);
  localparam logic [COORD_W-1:0] GRID_C = COORD_W'(GRID);
  localparam logic [ADDR_W-1:0] GRID_A = ADDR_W'(GRID);
  localparam logic [ADDR_W-1:0] LAST_BIN = ADDR_W'(BINS - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [DIR_W-1:0] DIR_E  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_N  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_NW = 3'd2;
  localparam logic [DIR_W-1:0] DIR_W_ = 3'd3;
  localparam logic [DIR_W-1:0] DIR_S  = 3'd4;
  localparam logic [DIR_W-1:0] DIR_SE = 3'd5;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic              rd;
    logic              hit;
    logic              done;
    logic [ADDR_W-1:0] addr;
    coord_t            pos_x;
    coord_t            pos_y;
  } op_t;

  function automatic coord_t off_x(input logic [DIR_W-1:0] dir);
    coord_t r;
    case (dir)
      DIR_E, DIR_SE:  r = COORD_W'(1);
      DIR_NW, DIR_W_: r = -COORD_W'(1);
      default:        r = '0;
    endcase
    return r;
  endfunction

  function automatic coord_t off_y(input logic [DIR_W-1:0] dir);
    coord_t r;
    case (dir)
      DIR_N, DIR_NW: r = COORD_W'(1);
      DIR_S, DIR_SE: r = -COORD_W'(1);
      default:       r = '0;
    endcase
    return r;
  endfunction

  function automatic count_t sat_inc(input count_t c);
    return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
  endfunction

endpackage
`default_nettype wire

// ----- hdl/twh_front.sv -----
// front end: walker position, walk length and beat classification
`default_nettype none
module twh_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic                          cmd,
  input  wire logic [twh_pkg::DIR_W-1:0]     direction,
  input  wire logic [twh_pkg::BIN_W-1:0]     bin_index,
  input  wire logic                          cfg_write,
  input  wire logic [twh_pkg::SPW_W-1:0]     cfg_data,
  output twh_pkg::op_t                       op
);

  logic [twh_pkg::SPW_W-1:0] steps_per_walk;
  logic [twh_pkg::SPW_W-1:0] step_counter;
  twh_pkg::coord_t walker_x;
  twh_pkg::coord_t walker_y;

  twh_pkg::coord_t nx;
  twh_pkg::coord_t ny;
  logic in_bounds;
  logic done;
  logic bin_ok;
  logic [twh_pkg::SPW_W:0] count_plus;
  logic [twh_pkg::ADDR_W-1:0] step_addr;

  always_comb begin
    nx = walker_x + twh_pkg::off_x(direction);
    ny = walker_y + twh_pkg::off_y(direction);
    in_bounds = !nx[twh_pkg::COORD_W-1] && !ny[twh_pkg::COORD_W-1] &&
                (nx < twh_pkg::GRID_C) && (ny < twh_pkg::GRID_C);
    step_addr = twh_pkg::ADDR_W'(nx) + twh_pkg::ADDR_W'(ny) * twh_pkg::GRID_A;
    count_plus = {1'b0, step_counter} + (twh_pkg::SPW_W + 1)'(1);
    done = count_plus >= {1'b0, steps_per_walk};
    bin_ok = 32'(bin_index) < 32'(twh_pkg::BINS);
    if (cmd == twh_pkg::CMD_READ) begin
      op.rd    = 1'b1;
      op.hit   = bin_ok;
      op.done  = 1'b0;
      op.addr  = twh_pkg::ADDR_W'(bin_index);
      op.pos_x = walker_x;
      op.pos_y = walker_y;
    end else begin
      op.rd    = 1'b0;
      op.hit   = in_bounds;
      op.done  = done;
      op.addr  = step_addr;
      op.pos_x = nx;
      op.pos_y = ny;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_walk <= twh_pkg::SPW_RESET;
    end else if (cfg_write) begin
      steps_per_walk <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walker_x <= twh_pkg::CENTER;
      walker_y <= twh_pkg::CENTER;
      step_counter <= '0;
    end else if (accept && cmd == twh_pkg::CMD_STEP) begin
      if (done) begin
        walker_x <= twh_pkg::CENTER;
        walker_y <= twh_pkg::CENTER;
        step_counter <= '0;
      end else begin
        walker_x <= nx;
        walker_y <= ny;
        step_counter <= count_plus[twh_pkg::SPW_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/twh_fifo.sv -----
// short queue of classified beats between front and back
`default_nettype none
module twh_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire twh_pkg::op_t  push_data,
  output logic               full,
  input  wire logic          pop,
  output twh_pkg::op_t       head,
  output logic               empty
);

  twh_pkg::op_t slots [twh_pkg::FIFO_DEPTH];
  logic [twh_pkg::PTR_W-1:0] wr_ptr;
  logic [twh_pkg::PTR_W-1:0] rd_ptr;
  logic [twh_pkg::FILL_W-1:0] fill;

  assign full  = fill == twh_pkg::FILL_W'(twh_pkg::FIFO_DEPTH);
  assign empty = fill == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == twh_pkg::PTR_W'(twh_pkg::FIFO_DEPTH - 1)) ? '0
                  : wr_ptr + twh_pkg::PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == twh_pkg::PTR_W'(twh_pkg::FIFO_DEPTH - 1)) ? '0
                  : rd_ptr + twh_pkg::PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + twh_pkg::FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - twh_pkg::FILL_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/twh_back.sv -----
// back end: histogram memories, clearing sweep, read-modify-write and result register
`default_nettype none
module twh_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire twh_pkg::op_t                   head,
  input  wire logic                           empty,
  output logic                                pop,
  output logic                                clearing,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output twh_pkg::coord_t                     pos_x,
  output twh_pkg::coord_t                     pos_y,
  output logic                                in_grid,
  output logic                                walk_done,
  output twh_pkg::count_t                     all_steps_count,
  output twh_pkg::count_t                     end_of_walk_count
);

  twh_pkg::count_t mem_all [twh_pkg::BINS];
  twh_pkg::count_t mem_fin [twh_pkg::BINS];

  logic [twh_pkg::ADDR_W-1:0] clr_addr;

  twh_pkg::op_t b_op;
  logic b_valid;
  logic b_fwd;
  twh_pkg::count_t rd_all;
  twh_pkg::count_t rd_fin;
  twh_pkg::count_t wr_all_q;
  twh_pkg::count_t wr_fin_q;

  twh_pkg::count_t cur_all;
  twh_pkg::count_t cur_fin;
  twh_pkg::count_t new_all;
  twh_pkg::count_t new_fin;
  logic b_move;
  logic step_wr;
  logic wr_en;
  logic [twh_pkg::ADDR_W-1:0] wr_addr;
  twh_pkg::count_t wr_all;
  twh_pkg::count_t wr_fin;

  always_comb begin
    b_move  = b_valid && (!out_valid || out_ready);
    pop     = !empty && (!b_valid || b_move);
    cur_all = b_fwd ? wr_all_q : rd_all;
    cur_fin = b_fwd ? wr_fin_q : rd_fin;
    new_all = twh_pkg::sat_inc(cur_all);
    new_fin = b_op.done ? twh_pkg::sat_inc(cur_fin) : cur_fin;
    step_wr = b_move && !b_op.rd && b_op.hit;
    wr_en   = clearing || step_wr;
    wr_addr = clearing ? clr_addr : b_op.addr;
    wr_all  = clearing ? '0 : new_all;
    wr_fin  = clearing ? '0 : new_fin;
  end

  // histogram storage, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_all[wr_addr] <= wr_all;
      mem_fin[wr_addr] <= wr_fin;
    end
    if (pop) begin
      rd_all <= mem_all[head.addr];
      rd_fin <= mem_fin[head.addr];
    end
  end

  // sweep zeros through both histograms after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + twh_pkg::ADDR_W'(1);
      if (clr_addr == twh_pkg::LAST_BIN) begin
        clearing <= 1'b0;
      end
    end
  end

  // last written values, used when a beat read the same bin on the write edge
  always_ff @(posedge clk) begin
    if (step_wr) begin
      wr_all_q <= new_all;
      wr_fin_q <= new_fin;
    end
    if (pop) begin
      b_op  <= head;
      b_fwd <= step_wr && (head.addr == b_op.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pop) begin
      b_valid <= 1'b1;
    end else if (b_move) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      pos_x     <= b_op.pos_x;
      pos_y     <= b_op.pos_y;
      in_grid   <= !b_op.rd && b_op.hit;
      walk_done <= b_op.done;
      all_steps_count   <= (b_op.rd && b_op.hit) ? cur_all : '0;
      end_of_walk_count <= (b_op.rd && b_op.hit) ? cur_fin : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/triangular_lattice_walk_histogram.sv -----
// top level: triangular lattice walk with all-steps and end-of-walk histograms
// path: a beat goes through the queue, the bin read register and the result register
// throughput: one beat per cycle unless stalled, set by one memory read-modify-write per beat
// the result register and a four-entry queue let input and output stall separately
// reset: synchronous; a sweep over all GRID*GRID bins (1024) zeroes both histograms,
// in_ready stays low during it while configuration writes are taken as ever
`default_nettype none
module triangular_lattice_walk_histogram (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          cmd,
  input  wire logic [twh_pkg::DIR_W-1:0]     direction,
  input  wire logic [twh_pkg::BIN_W-1:0]     bin_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output twh_pkg::coord_t                    pos_x,
  output twh_pkg::coord_t                    pos_y,
  output logic                               in_grid,
  output logic                               walk_done,
  output twh_pkg::count_t                    all_steps_count,
  output twh_pkg::count_t                    end_of_walk_count,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [twh_pkg::SPW_W-1:0]     cfg_data
);

  twh_pkg::op_t op;
  twh_pkg::op_t head;
  logic full;
  logic empty;
  logic pop;
  logic clearing;
  logic accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full && !clearing;
  assign accept    = in_valid && in_ready;

  twh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (cmd),
    .direction (direction),
    .bin_index (bin_index),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .op        (op)
  );

  twh_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (op),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  twh_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head              (head),
    .empty             (empty),
    .pop               (pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .in_grid           (in_grid),
    .walk_done         (walk_done),
    .all_steps_count   (all_steps_count),
    .end_of_walk_count (end_of_walk_count)
  );

endmodule
`default_nettype wire

// ----- dv/twh_walk_checker.sv -----
// checker: mirrors the walker and both histograms and compares every result beat
module twh_walk_checker
  import twh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               cmd,
  input  logic [DIR_W-1:0]   direction,
  input  logic [BIN_W-1:0]   bin_index,
  input  logic               out_valid,
  input  logic               out_ready,
  input  coord_t             pos_x,
  input  coord_t             pos_y,
  input  logic               in_grid,
  input  logic               walk_done,
  input  count_t             all_steps_count,
  input  count_t             end_of_walk_count,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [SPW_W-1:0]   cfg_data,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   hit;
    logic   ended;
    count_t all_cnt;
    count_t end_cnt;
  } walk_result_t;

  coord_t             walker_x;
  coord_t             walker_y;
  logic [SPW_W-1:0]   walk_len;
  logic [SPW_W-1:0]   walk_limit;
  count_t             visit_hist [BINS];
  count_t             end_hist [BINS];
  walk_result_t       due_results [$];

  initial errors = 0;
  initial pending = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [COUNT_W-1:0] got,
                             input logic [COUNT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic count_t bump(input count_t c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  // one beat in, one expected result out; steps also move the walker and fill bins
  function automatic walk_result_t predict_beat(input logic c, input logic [DIR_W-1:0] d,
                                                input logic [BIN_W-1:0] b);
    walk_result_t r;
    coord_t       dx;
    coord_t       dy;
    coord_t       nx;
    coord_t       ny;
    int           ix;
    int           iy;
    int           bin;
    r = '0;
    if (c == CMD_READ) begin
      r.x = walker_x;
      r.y = walker_y;
      if (int'(b) < BINS) begin
        r.all_cnt = visit_hist[b];
        r.end_cnt = end_hist[b];
      end
      return r;
    end
    dx = '0;
    dy = '0;
    case (d)
      DIR_E: dx = 1;
      DIR_N: dy = 1;
      DIR_NW: begin
        dx = -1;
        dy = 1;
      end
      DIR_W_: dx = -1;
      DIR_S: dy = -1;
      DIR_SE: begin
        dx = 1;
        dy = -1;
      end
      default: ;
    endcase
    nx = walker_x + dx;
    ny = walker_y + dy;
    ix = nx;
    iy = ny;
    bin = ix + iy * GRID;
    r.x = nx;
    r.y = ny;
    r.hit = (ix >= 0) && (ix < GRID) && (iy >= 0) && (iy < GRID);
    r.ended = (int'(walk_len) + 1) >= int'(walk_limit);
    if (r.hit) visit_hist[bin] = bump(visit_hist[bin]);
    if (r.ended) begin
      if (r.hit) end_hist[bin] = bump(end_hist[bin]);
      walker_x = CENTER;
      walker_y = CENTER;
      walk_len = '0;
    end else begin
      walker_x = nx;
      walker_y = ny;
      walk_len = walk_len + 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    walk_result_t got;
    walk_result_t want;
    if (rst) begin
      walker_x = CENTER;
      walker_y = CENTER;
      walk_len = '0;
      walk_limit = SPW_RESET;
      for (int i = 0; i < BINS; i++) begin
        visit_hist[i] = '0;
        end_hist[i] = '0;
      end
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) walk_limit = cfg_data;
      if (out_valid && out_ready) begin
        got = '{pos_x, pos_y, in_grid, walk_done, all_steps_count, end_of_walk_count};
        if (due_results.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = due_results.pop_front();
          check_field("pos_x", COUNT_W'(got.x), COUNT_W'(want.x));
          check_field("pos_y", COUNT_W'(got.y), COUNT_W'(want.y));
          check_field("in_grid", COUNT_W'(got.hit), COUNT_W'(want.hit));
          check_field("walk_done", COUNT_W'(got.ended), COUNT_W'(want.ended));
          check_field("all_steps_count", got.all_cnt, want.all_cnt);
          check_field("end_of_walk_count", got.end_cnt, want.end_cnt);
        end
      end
      if (in_valid && in_ready) due_results.push_back(predict_beat(cmd, direction, bin_index));
    end
    pending <= due_results.size();
  end

endmodule

// ----- dv/tb_triangular_lattice_walk_histogram.sv -----
// testbench top: drives steps, bin reads and walk length writes, gives the verdict
module tb_triangular_lattice_walk_histogram;
  import twh_pkg::*;

  localparam int CLK_HALF = 6;
  localparam logic [DIR_W-1:0] DIR_NOP_A = 3'd6;
  localparam logic [DIR_W-1:0] DIR_NOP_B = 3'd7;
  localparam logic [BIN_W-1:0] CENTER_BIN = BIN_W'(GRID / 2 + (GRID / 2) * GRID);

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             cmd = CMD_STEP;
  logic [DIR_W-1:0] direction = DIR_E;
  logic [BIN_W-1:0] bin_index = '0;
  logic             out_ready = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [SPW_W-1:0] cfg_data = '0;
  logic             in_ready;
  logic             out_valid;
  logic             cfg_ready;
  coord_t           pos_x;
  coord_t           pos_y;
  logic             in_grid;
  logic             walk_done;
  count_t           all_steps_count;
  count_t           end_of_walk_count;
  int               errors;
  int               pending;
  int               idle_pct = 0;
  int               stall_pct = 0;

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  triangular_lattice_walk_histogram dut (.*);

  twh_walk_checker u_checker (.*);

  // valid stays high across back-to-back beats; it drops only for a gap
  task automatic send_item(input logic c, input logic [DIR_W-1:0] d,
                           input logic [BIN_W-1:0] b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    direction <= d;
    bin_index <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_walk_len(input logic [SPW_W-1:0] v);
    // let the pipeline settle
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly drifting walks with a lead direction, then a few bin reads; some noise
  task automatic run_walks(input logic [SPW_W-1:0] walk_len, input int idle,
                           input int stall, input int n);
    int               sent;
    int               burst;
    int               reads;
    logic [DIR_W-1:0] lead;
    drain();
    write_walk_len(walk_len);
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) < 8) begin
        lead = DIR_W'($urandom_range(5));
        burst = $urandom_range(30, 1);
        reads = $urandom_range(3, 1);
        repeat (burst)
          send_item(CMD_STEP, ($urandom_range(3) != 0) ? lead : DIR_W'($urandom_range(7)),
                    BIN_W'($urandom()));
        repeat (reads) send_item(CMD_READ, DIR_W'($urandom()), BIN_W'($urandom()));
        sent += burst + reads;
      end else begin
        send_item(1'($urandom()), DIR_W'($urandom()), BIN_W'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // every direction, the two unused codes, then reads of touched and edge bins
    send_item(CMD_STEP, DIR_E, '0);
    send_item(CMD_STEP, DIR_N, '1);
    send_item(CMD_STEP, DIR_NW, '0);
    send_item(CMD_STEP, DIR_W_, '1);
    send_item(CMD_STEP, DIR_S, '0);
    send_item(CMD_STEP, DIR_SE, '1);
    send_item(CMD_STEP, DIR_NOP_A, '0);
    send_item(CMD_STEP, DIR_NOP_B, '1);
    send_item(CMD_READ, DIR_E, CENTER_BIN);
    send_item(CMD_READ, DIR_NOP_B, CENTER_BIN + 1'b1);
    send_item(CMD_READ, DIR_E, '0);
    send_item(CMD_READ, DIR_NOP_B, '1);
    send_item(CMD_READ, DIR_E, 10'h155);
    send_item(CMD_READ, DIR_NOP_B, 10'h2aa);

    // zero walk length ends every step
    drain();
    write_walk_len('0);
    send_item(CMD_STEP, DIR_N, '0);
    send_item(CMD_STEP, DIR_S, '0);
    send_item(CMD_READ, DIR_E, CENTER_BIN + BIN_W'(GRID));

    // longest walk, then the length drops below the steps already taken
    drain();
    write_walk_len('1);
    repeat (4) send_item(CMD_STEP, DIR_W_, '0);
    drain();
    write_walk_len(SPW_W'(3));
    send_item(CMD_STEP, DIR_W_, '0);
    send_item(CMD_READ, DIR_E, CENTER_BIN - BIN_W'(5));

    run_walks(SPW_RESET, 0, 0, 100);
    run_walks('1, 86, 0, 100);
    run_walks(SPW_W'(1), 0, 86, 100);
    run_walks(SPW_W'(7), 15, 15, 100);
    run_walks(SPW_W'($urandom_range(60, 2)), 0, 0, 100);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(CLK_HALF * 2 * 300000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
